// ----- rtl/hidkbd_pkg.sv -----
// Shared types and constants for the boot-keyboard report block.
`timescale 1ns / 1ps
`default_nettype none

package hidkbd_pkg;

    localparam int KEY_SLOTS_DEF = 6;
    localparam int LAYOUT_DEPTH  = 128;
    localparam int LAYOUT_AW     = $clog2(LAYOUT_DEPTH);

    typedef enum logic [2:0] {
        FUNC_PRESS       = 3'd0,
        FUNC_RELEASE     = 3'd1,
        FUNC_PRESS_RAW   = 3'd2,
        FUNC_RELEASE_RAW = 3'd3,
        FUNC_RELEASE_ALL = 3'd4,
        FUNC_LOAD_LAYOUT = 3'd5,
        FUNC_HOST_LEDS   = 3'd6
    } func_t;

    // key codes
    localparam logic [7:0] KEY_CODE_BASE = 8'h88;
    localparam logic [7:0] KEY_MOD_BASE  = 8'h80;

    // HID usages
    localparam logic [7:0] USAGE_MOD_FIRST = 8'hE0;
    localparam logic [7:0] USAGE_MOD_END   = 8'hE8;
    localparam logic [7:0] USAGE_KEY_END   = 8'hA5;
    localparam logic [7:0] USAGE_NONUS     = 8'h32;
    localparam logic [7:0] USAGE_ISO       = 8'h64;

    // modifier byte masks
    localparam logic [7:0] MOD_SHIFT = 8'h02;
    localparam logic [7:0] MOD_ALTGR = 8'h40;

    // layout entry flag bits
    localparam int ENTRY_SHIFT_BIT = 7;
    localparam int ENTRY_ALTGR_BIT = 6;

    localparam int LED_CAPS_BIT = 1;

endpackage

`default_nettype wire

// ----- rtl/hid_boot_keyboard_report.sv -----
// Boot-keyboard report keeper: report state, layout table and caps-lock flag.
// Pipeline: input register with layout read, then result register.
// Throughput: one transaction per cycle while out_stall is low; the layout RAM read port is used by every item.
// Reset: clears modifier byte, key slots, caps flag and the pipeline valids;
// the layout table is not cleared and holds no meaning until loaded.
`timescale 1ns / 1ps
`default_nettype none

module hid_boot_keyboard_report
    import hidkbd_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] func,
    input  wire logic [7:0] key_code,
    input  wire logic [6:0] layout_index,
    input  wire logic [7:0] layout_entry,
    input  wire logic [7:0] led_byte,
    input  wire logic       led_present,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            accepted,
    output logic            report_sent,
    output logic [7:0]      modifier_bits,
    output logic [7:0]      slot0,
    output logic [7:0]      slot1,
    output logic [7:0]      slot2,
    output logic [7:0]      slot3,
    output logic [7:0]      slot4,
    output logic [7:0]      slot5,
    output logic            caps_lock
);

    logic       s1_valid_reg;
    func_t      s1_func_reg;
    logic [7:0] s1_key_reg;
    logic       s1_present_reg;
    logic       s1_caps_reg;

    logic       out_valid_reg;
    logic       accepted_reg;
    logic       sent_reg;

    logic [7:0] modifier_reg;
    logic [7:0] modifier_next;
    logic [7:0] slots_reg  [KEY_SLOTS];
    logic [7:0] slots_next [KEY_SLOTS];
    logic       caps_reg;
    logic       caps_next;
    logic       accepted_next;
    logic       sent_next;

    logic       in_accept;
    logic       advance;
    logic [7:0] layout_rdata;
    logic [7:0] slot_view [6];

    // combinational working values
    logic       pressing;
    logic       do_press;
    logic       do_release;
    logic [7:0] usage;
    logic [7:0] entry;
    logic       held;
    logic       found;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    hidkbd_ram #(
        .WIDTH (8),
        .DEPTH (LAYOUT_DEPTH)
    ) u_layout (
        .clk     (clk),
        .wr_en   (in_accept && (func == FUNC_LOAD_LAYOUT)),
        .wr_addr (layout_index[LAYOUT_AW-1:0]),
        .wr_data (layout_entry),
        .rd_en   (in_accept),
        .rd_addr (key_code[LAYOUT_AW-1:0]),
        .rd_data (layout_rdata)
    );

    always_comb
    begin
        modifier_next = modifier_reg;
        slots_next    = slots_reg;
        caps_next     = caps_reg;
        accepted_next = 1'b0;
        sent_next     = 1'b0;
        pressing      = (s1_func_reg == FUNC_PRESS);
        do_press      = 1'b0;
        do_release    = 1'b0;
        usage         = s1_key_reg;
        entry         = layout_rdata;
        held          = 1'b0;
        found         = 1'b0;

        unique case (s1_func_reg)
            FUNC_PRESS, FUNC_RELEASE:
            begin
                if (s1_key_reg >= KEY_CODE_BASE)
                begin
                    usage      = s1_key_reg - KEY_CODE_BASE;
                    do_press   = pressing;
                    do_release = !pressing;
                end
                else if (s1_key_reg >= KEY_MOD_BASE)
                begin
                    if (pressing)
                        modifier_next = modifier_next | (8'h01 << s1_key_reg[2:0]);
                    else
                        modifier_next = modifier_next & ~(8'h01 << s1_key_reg[2:0]);
                    usage      = '0;
                    do_press   = pressing;
                    do_release = !pressing;
                end
                else if (entry != 8'h00)
                begin
                    // apply shift and AltGr from the layout, then ISO substitution
                    if (entry[ENTRY_SHIFT_BIT])
                        modifier_next = pressing ? (modifier_next | MOD_SHIFT)
                                                 : (modifier_next & ~MOD_SHIFT);
                    if (entry[ENTRY_ALTGR_BIT])
                        modifier_next = pressing ? (modifier_next | MOD_ALTGR)
                                                 : (modifier_next & ~MOD_ALTGR);
                    usage = {2'b00, entry[5:0]};
                    if (usage == USAGE_NONUS)
                        usage = USAGE_ISO;
                    do_press   = pressing;
                    do_release = !pressing;
                end
            end
            FUNC_PRESS_RAW:   do_press = 1'b1;
            FUNC_RELEASE_RAW: do_release = 1'b1;
            FUNC_RELEASE_ALL:
            begin
                modifier_next = '0;
                for (int s = 0; s < KEY_SLOTS; s++)
                    slots_next[s] = '0;
                accepted_next = 1'b1;
                sent_next     = 1'b1;
            end
            FUNC_LOAD_LAYOUT: accepted_next = 1'b1;
            FUNC_HOST_LEDS:
            begin
                if (s1_present_reg)
                    caps_next = s1_caps_reg;
                accepted_next = 1'b1;
            end
            default: ;
        endcase

        if (do_press)
        begin
            if (usage >= USAGE_MOD_FIRST && usage < USAGE_MOD_END)
            begin
                modifier_next = modifier_next | (8'h01 << usage[2:0]);
                accepted_next = 1'b1;
            end
            else if (usage != 8'h00 && usage < USAGE_KEY_END)
            begin
                for (int s = 0; s < KEY_SLOTS; s++)
                    if (slots_reg[s] == usage)
                        held = 1'b1;
                // fill the lowest free slot unless already held
                for (int s = 0; s < KEY_SLOTS; s++)
                begin
                    if (!found && slots_reg[s] == 8'h00)
                    begin
                        found = 1'b1;
                        if (!held)
                            slots_next[s] = usage;
                    end
                end
                accepted_next = held || found;
            end
            else
            begin
                accepted_next = (modifier_next != 8'h00);
            end
            sent_next = accepted_next;
        end

        if (do_release)
        begin
            if (usage >= USAGE_MOD_FIRST && usage < USAGE_MOD_END)
                modifier_next = modifier_next & ~(8'h01 << usage[2:0]);
            else if (usage != 8'h00 && usage < USAGE_KEY_END)
                for (int s = 0; s < KEY_SLOTS; s++)
                    if (slots_reg[s] == usage)
                        slots_next[s] = '0;
            accepted_next = 1'b1;
            sent_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            modifier_reg  <= '0;
            caps_reg      <= 1'b0;
            for (int s = 0; s < KEY_SLOTS; s++)
                slots_reg[s] <= '0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                modifier_reg  <= modifier_next;
                slots_reg     <= slots_next;
                caps_reg      <= caps_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg    <= func_t'(func);
            s1_key_reg     <= key_code;
            s1_present_reg <= led_present;
            s1_caps_reg    <= led_byte[LED_CAPS_BIT];
        end
        if (advance)
        begin
            accepted_reg <= accepted_next;
            sent_reg     <= sent_next;
        end
    end

    // report state only changes on advance, so it matches the held result
    for (genvar j = 0; j < 6; j++)
    begin : g_view
        if (j < KEY_SLOTS)
        begin : g_on
            assign slot_view[j] = slots_reg[j];
        end
        else
        begin : g_off
            assign slot_view[j] = '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign report_sent   = sent_reg;
    assign modifier_bits = modifier_reg;
    assign slot0         = slot_view[0];
    assign slot1         = slot_view[1];
    assign slot2         = slot_view[2];
    assign slot3         = slot_view[3];
    assign slot4         = slot_view[4];
    assign slot5         = slot_view[5];
    assign caps_lock     = caps_reg;

`ifndef ASSERT_OFF
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_sent_implies_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!report_sent || accepted))
        else $error("report sent for a rejected transaction");

    a_release_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_func_reg == FUNC_RELEASE_ALL)
            |=> (modifier_bits == 8'h00 && slot0 == 8'h00 && report_sent))
        else $error("release all left report contents");

    a_load_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_func_reg == FUNC_LOAD_LAYOUT)
            |=> (accepted && !report_sent && $stable(modifier_bits)))
        else $error("layout load disturbed the report");
`endif

endmodule

`default_nettype wire

// ----- rtl/hidkbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hidkbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
